/* src/dtcg_pkg.sv */
// shared constants, types and helper function of the time code generator
`default_nettype none

package dtcg_pkg;

   // telegram length and idle bit position
   localparam int TelegramBits = 59;
   localparam int PosWidth = 6;
   localparam logic [PosWidth-1:0] IdlePosition = 6'd59;

   // configuration register width and reset values
   localparam int CfgWidth = 10;
   localparam logic [CfgWidth-1:0] ShortPulseReset = 10'd100;
   localparam logic [CfgWidth-1:0] LongPulseReset = 10'd200;
   localparam logic [CfgWidth-1:0] BitPeriodReset = 10'd1000;
   localparam int CsrAddrWidth = 2;

   // telegram bit positions
   localparam int AnnounceBit = 16;
   localparam int SummerBit = 17;
   localparam int WinterBit = 18;
   localparam int StartBit = 20;
   localparam int MinLo = 21;
   localparam int MinHi = 27;
   localparam int MinParityBit = 28;
   localparam int HourLo = 29;
   localparam int HourHi = 34;
   localparam int HourParityBit = 35;
   localparam int DateLo = 36;
   localparam int WeekdayLo = 42;
   localparam int MonthLo = 45;
   localparam int YearLo = 50;
   localparam int DateHi = 57;
   localparam int DateParityBit = 58;

   // calendar codes
   localparam logic [2:0] Sunday = 3'd7;
   localparam logic [3:0] March = 4'd3;
   localparam logic [3:0] October = 4'd10;
   localparam logic [4:0] LastWeekStart = 5'd25;

   // configuration register indexes
   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_SHORT_PULSE = 2'd0,
      CSR_LONG_PULSE  = 2'd1,
      CSR_BIT_PERIOD  = 2'd2
   } csr_reg_type;

   // request action codes
   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_LOAD = 1'b1
   } action_type;

   // configuration register set
   typedef struct packed {
      logic [CfgWidth-1:0] short_pulse_ticks;
      logic [CfgWidth-1:0] long_pulse_ticks;
      logic [CfgWidth-1:0] bit_period_ticks;
   } cfg_type;

   // time fields of a load request
   typedef struct packed {
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day_of_month;
      logic [2:0] weekday;
      logic [3:0] month;
      logic [6:0] year_in_century;
      logic       summer_time;
   } time_type;

   // a value split into decimal tens and units
   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] units;
   } bcd_type;

   // tens by reciprocal multiply (exact for every 7-bit input), units by subtraction
   function automatic bcd_type bcd_split(input logic [6:0] value);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  rest;
      bcd_type     res;
      prod = 15'(value) * 15'd205;
      tens = prod[14:11];
      rest = value - 7'(tens) * 7'd10;
      res.tens = tens;
      res.units = rest[3:0];
      return res;
   endfunction

endpackage

`default_nettype wire

/* src/dtcg_if.sv */
// handshake channel interfaces for request, response and configuration
`default_nettype none

// request channel: tick or load with the time to announce
interface dtcg_req_if import dtcg_pkg::*;;
   logic       valid;
   logic       ready;
   logic       action;
   logic [5:0] minute;
   logic [4:0] hour;
   logic [4:0] day_of_month;
   logic [2:0] weekday;
   logic [3:0] month;
   logic [6:0] year_in_century;
   logic       summer_time;

   modport source (output valid, action, minute, hour, day_of_month, weekday, month,
                   year_in_century, summer_time, input ready);
   modport sink (input valid, action, minute, hour, day_of_month, weekday, month,
                 year_in_century, summer_time, output ready);
endinterface

// response channel: line level and progress for each request
interface dtcg_rsp_if import dtcg_pkg::*;;
   logic                valid;
   logic                ready;
   logic                pulse_out;
   logic                busy_res;
   logic [PosWidth-1:0] bit_position;
   logic                frame_done;

   modport source (output valid, pulse_out, busy_res, bit_position, frame_done,
                   input ready);
   modport sink (input valid, pulse_out, busy_res, bit_position, frame_done,
                 output ready);
endinterface

// configuration write channel
interface dtcg_csr_if import dtcg_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [CsrAddrWidth-1:0] addr;
   logic [CfgWidth-1:0]     data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

/* src/dcf77_time_code_generator_unit.sv */
// top level of the minute telegram generator
// A load request latches the time to announce and starts a 59-bit minute telegram;
// each later tick request sends one tick of the current bit as a short (zero) or
// long (one) high pulse at the head of the bit period, and yields one response
// with the line level, busy flag, bit index (59 when idle) and a done flag on the
// tick that ends the last bit. Every request takes one clock cycle and a new one
// is accepted each cycle while the response register is free or being read; the
// telegram is built in the same cycle as the load. Pulse and period lengths are
// written through the configuration channel while no request is in flight.
`default_nettype none

module dcf77_time_code_generator_unit import dtcg_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   dtcg_req_if.sink   req_ch,
   dtcg_rsp_if.source rsp_ch,
   dtcg_csr_if.sink   csr_ch
);

   cfg_type                 cfg;
   time_type                time_fields;
   logic [TelegramBits-1:0] built_telegram;

   // configuration
   dtcg_csr_regs u_csr_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // time fields of the request
   assign time_fields.minute = req_ch.minute;
   assign time_fields.hour = req_ch.hour;
   assign time_fields.day_of_month = req_ch.day_of_month;
   assign time_fields.weekday = req_ch.weekday;
   assign time_fields.month = req_ch.month;
   assign time_fields.year_in_century = req_ch.year_in_century;
   assign time_fields.summer_time = req_ch.summer_time;

   dtcg_telegram_builder u_builder (
      .time_fields (time_fields),
      .telegram    (built_telegram)
   );

   // sequencing and response register
   dtcg_frame_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .built_telegram (built_telegram),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch)
   );

endmodule

`default_nettype wire

/* src/dtcg_csr_regs.sv */
// configuration registers for pulse and bit period lengths
`default_nettype none

module dtcg_csr_regs import dtcg_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   dtcg_csr_if.sink  csr_ch,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   // decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_reg_type'(csr_ch.addr))
            CSR_SHORT_PULSE: cfg_in.short_pulse_ticks = csr_ch.data;
            CSR_LONG_PULSE:  cfg_in.long_pulse_ticks = csr_ch.data;
            CSR_BIT_PERIOD:  cfg_in.bit_period_ticks = csr_ch.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_pulse_ticks <= ShortPulseReset;
         cfg_ff.long_pulse_ticks <= LongPulseReset;
         cfg_ff.bit_period_ticks <= BitPeriodReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* src/dtcg_telegram_builder.sv */
// builds the minute telegram from the time fields of a load request
`default_nettype none

module dtcg_telegram_builder import dtcg_pkg::*; (
   input  wire time_type            time_fields,
   output logic [TelegramBits-1:0]  telegram
);

   bcd_type min_bcd;
   bcd_type hour_bcd;
   bcd_type day_bcd;
   bcd_type month_bcd;
   bcd_type year_bcd;
   logic    last_sunday;
   logic    announce;

   // decimal split of each field
   assign min_bcd = bcd_split(7'(time_fields.minute));
   assign hour_bcd = bcd_split(7'(time_fields.hour));
   assign day_bcd = bcd_split(7'(time_fields.day_of_month));
   assign month_bcd = bcd_split(7'(time_fields.month));
   assign year_bcd = bcd_split(time_fields.year_in_century);

   // daylight saving change on the last sunday of march or october
   assign last_sunday = (time_fields.weekday == Sunday) &&
                        (time_fields.day_of_month >= LastWeekStart);
   assign announce = last_sunday &&
      (((time_fields.month == March) && (time_fields.hour == 5'd1) &&
        !time_fields.summer_time) ||
       ((time_fields.month == October) && (time_fields.hour == 5'd2) &&
        time_fields.summer_time));

   // assemble fields and even parity bits
   always_comb begin
      telegram = '0;
      telegram[AnnounceBit] = announce;
      telegram[SummerBit] = time_fields.summer_time;
      telegram[WinterBit] = !time_fields.summer_time;
      telegram[StartBit] = 1'b1;
      telegram[MinLo +: 4] = min_bcd.units;
      telegram[MinLo+4 +: 3] = min_bcd.tens[2:0];
      telegram[MinParityBit] = ^telegram[MinHi:MinLo];
      telegram[HourLo +: 4] = hour_bcd.units;
      telegram[HourLo+4 +: 2] = hour_bcd.tens[1:0];
      telegram[HourParityBit] = ^telegram[HourHi:HourLo];
      telegram[DateLo +: 4] = day_bcd.units;
      telegram[DateLo+4 +: 2] = day_bcd.tens[1:0];
      telegram[WeekdayLo +: 3] = time_fields.weekday;
      telegram[MonthLo +: 4] = month_bcd.units;
      telegram[MonthLo+4] = month_bcd.tens[0];
      telegram[YearLo +: 4] = year_bcd.units;
      telegram[YearLo+4 +: 4] = year_bcd.tens;
      telegram[DateParityBit] = ^telegram[DateHi:DateLo];
   end

endmodule

`default_nettype wire

/* src/dtcg_frame_engine.sv */
// bit and tick sequencing with the registered response stage
`default_nettype none

module dtcg_frame_engine import dtcg_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic [TelegramBits-1:0] built_telegram,
   dtcg_req_if.sink                 req_ch,
   dtcg_rsp_if.source               rsp_ch
);

   logic [TelegramBits-1:0] telegram_ff, telegram_in;
   logic [PosWidth-1:0]     bit_ff, bit_in;
   logic [CfgWidth-1:0]     tick_ff, tick_in;
   logic                    sending_ff, sending_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    pulse_ff, pulse_in;
   logic                    busy_ff, busy_in;
   logic [PosWidth-1:0]     pos_ff, pos_in;
   logic                    done_ff, done_in;

   logic                    accept;
   logic                    bit_one;
   logic [CfgWidth-1:0]     high_ticks;
   logic [CfgWidth:0]       tick_sum;
   logic [PosWidth-1:0]     bit_next;

   // a request is taken whenever the response slot is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   assign bit_one = telegram_ff[bit_ff];
   assign high_ticks = bit_one ? cfg.long_pulse_ticks : cfg.short_pulse_ticks;
   assign tick_sum = {1'b0, tick_ff} + (CfgWidth+1)'(1);
   assign bit_next = bit_ff + PosWidth'(1);

   // next state and response for the accepted request
   always_comb begin
      telegram_in = telegram_ff;
      bit_in = bit_ff;
      tick_in = tick_ff;
      sending_in = sending_ff;
      pulse_in = pulse_ff;
      busy_in = busy_ff;
      pos_in = pos_ff;
      done_in = done_ff;
      if (accept) begin
         if (action_type'(req_ch.action) == ACT_LOAD) begin
            telegram_in = built_telegram;
            bit_in = '0;
            tick_in = '0;
            sending_in = 1'b1;
            pulse_in = 1'b0;
            busy_in = 1'b1;
            pos_in = '0;
            done_in = 1'b0;
         end else if (!sending_ff) begin
            pulse_in = 1'b0;
            busy_in = 1'b0;
            pos_in = IdlePosition;
            done_in = 1'b0;
         end else begin
            pulse_in = tick_ff < high_ticks;
            busy_in = 1'b1;
            pos_in = bit_ff;
            done_in = 1'b0;
            if (tick_sum >= {1'b0, cfg.bit_period_ticks}) begin
               tick_in = '0;
               if (bit_next >= PosWidth'(TelegramBits)) begin
                  sending_in = 1'b0;
                  bit_in = IdlePosition;
                  done_in = 1'b1;
               end else begin
                  bit_in = bit_next;
               end
            end else begin
               tick_in = tick_sum[CfgWidth-1:0];
            end
         end
      end
   end

   // response slot holds until taken
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         telegram_ff <= '0;
         bit_ff <= IdlePosition;
         tick_ff <= '0;
         sending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         telegram_ff <= telegram_in;
         bit_ff <= bit_in;
         tick_ff <= tick_in;
         sending_ff <= sending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      pulse_ff <= pulse_in;
      busy_ff <= busy_in;
      pos_ff <= pos_in;
      done_ff <= done_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pulse_out = pulse_ff;
   assign rsp_ch.busy_res = busy_ff;
   assign rsp_ch.bit_position = pos_ff;
   assign rsp_ch.frame_done = done_ff;

endmodule

`default_nettype wire

/* src/dtcg_checker.sv */
// port level checks of the generator, bound to the top level
`default_nettype none

module dtcg_checker import dtcg_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                req_action,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                rsp_pulse_out,
   input wire logic                rsp_busy_res,
   input wire logic [PosWidth-1:0] rsp_bit_position,
   input wire logic                rsp_frame_done
);

   // response is withdrawn only after it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response present after reset");

   // a load answers with the start of a frame
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (action_type'(req_action) == ACT_LOAD) |=>
         rsp_valid && rsp_busy_res && !rsp_pulse_out && (rsp_bit_position == '0) &&
         !rsp_frame_done)
      else $error("load response wrong");

   // idle responses show the line low at the idle position
   a_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |->
         !rsp_pulse_out && !rsp_frame_done && (rsp_bit_position == IdlePosition))
      else $error("idle response wrong");

   // the frame ends on the last bit
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |->
         rsp_busy_res && (rsp_bit_position == PosWidth'(TelegramBits - 1)))
      else $error("frame done outside the last bit");

endmodule

bind dcf77_time_code_generator_unit dtcg_checker u_dtcg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_action       (req_ch.action),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_pulse_out    (rsp_ch.pulse_out),
   .rsp_busy_res     (rsp_ch.busy_res),
   .rsp_bit_position (rsp_ch.bit_position),
   .rsp_frame_done   (rsp_ch.frame_done)
);

`default_nettype wire
